FILE: sv/box_average_downscaler_defines.svh
// assertion macros of the box average downscaler
`ifndef BOX_AVERAGE_DOWNSCALER_DEFINES_SVH
`define BOX_AVERAGE_DOWNSCALER_DEFINES_SVH

// same-cycle implication, off while reset is low
`define BXAVG_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off while reset is low
`define BXAVG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/bxavg_pkg.sv
// shared constants, types and tables of the box average downscaler
package bxavg_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_BLOCK  = 16;
    localparam int MAX_HEIGHT = 4096;

    localparam int PIX_W      = 8;
    localparam int SIDE_W     = 5;
    localparam int WIDTH_W    = 11;
    localparam int HEIGHT_W   = 13;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = $clog2(MAX_HEIGHT);
    localparam int BLK_W = $clog2(MAX_BLOCK);
    localparam int RUN_W = PIX_W + BLK_W;
    localparam int SUM_W = PIX_W + 2 * BLK_W;

    // quotient = (sum * ceil(2^RECIP_SHIFT / area)) >> RECIP_SHIFT, exact for SUM_W bit sums
    localparam int RECIP_SHIFT = 24;
    localparam int RECIP_W     = RECIP_SHIFT + 1;
    localparam int PROD_W      = SUM_W + RECIP_W;

    // output queue depth, a power of two
    localparam int OQ_DEPTH = 4;
    localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
    localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);

    localparam int MOD_STEPS = HEIGHT_W;
    localparam int MOD_CNT_W = $clog2(MOD_STEPS + 1);

    localparam logic [SIDE_W-1:0]   RST_BLOCK_SIDE   = SIDE_W'(2);
    localparam logic [WIDTH_W-1:0]  RST_IMAGE_WIDTH  = WIDTH_W'(640);
    localparam logic [HEIGHT_W-1:0] RST_IMAGE_HEIGHT = HEIGHT_W'(480);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BLOCK_SIDE   = 2'd0,
        CFG_IMAGE_WIDTH  = 2'd1,
        CFG_IMAGE_HEIGHT = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [BLK_W-1:0]   side_m1;
        logic [COL_W-1:0]   width_m1;
        logic [ROW_W-1:0]   height_m1;
        logic [COL_W:0]     used_cols;
        logic [ROW_W:0]     used_rows;
        logic [RECIP_W-1:0] recip;
    } t_geom;

    typedef struct packed {
        logic             en;
        logic [COL_W-1:0] addr;
    } t_mem_rd;

    typedef struct packed {
        logic             en;
        logic [COL_W-1:0] addr;
        logic [SUM_W-1:0] data;
    } t_mem_wr;

    typedef struct packed {
        logic             valid;
        logic [SUM_W-1:0] total;
        logic             row_end;
        logic             frame_end;
    } t_div_req;

    typedef struct packed {
        logic [PIX_W-1:0] average_value;
        logic             row_end;
        logic             frame_end;
    } t_out_item;

    // ceil(2^24 / side^2) for side = side_m1 + 1
    function automatic logic [RECIP_W-1:0] recip_of(input logic [BLK_W-1:0] side_m1);
        logic [RECIP_W-1:0] r;
        unique case (side_m1)
            4'd0:  r = RECIP_W'(16777216);
            4'd1:  r = RECIP_W'(4194304);
            4'd2:  r = RECIP_W'(1864136);
            4'd3:  r = RECIP_W'(1048576);
            4'd4:  r = RECIP_W'(671089);
            4'd5:  r = RECIP_W'(466034);
            4'd6:  r = RECIP_W'(342393);
            4'd7:  r = RECIP_W'(262144);
            4'd8:  r = RECIP_W'(207127);
            4'd9:  r = RECIP_W'(167773);
            4'd10: r = RECIP_W'(138655);
            4'd11: r = RECIP_W'(116509);
            4'd12: r = RECIP_W'(99274);
            4'd13: r = RECIP_W'(85599);
            4'd14: r = RECIP_W'(74566);
            4'd15: r = RECIP_W'(65536);
        endcase
        return r;
    endfunction

endpackage

FILE: sv/bxavg_if.sv
// channel interfaces of the box average downscaler
interface bxavg_pix_if;
    logic                        valid;
    logic                        ready;
    logic [bxavg_pkg::PIX_W-1:0] pixel_value;
    logic                        frame_start;

    modport source (output valid, pixel_value, frame_start, input ready);
    modport sink   (input valid, pixel_value, frame_start, output ready);
endinterface

interface bxavg_res_if;
    logic                        valid;
    logic                        ready;
    logic [bxavg_pkg::PIX_W-1:0] average_value;
    logic                        row_end;
    logic                        frame_end;

    modport source (output valid, average_value, row_end, frame_end, input ready);
    modport sink   (input valid, average_value, row_end, frame_end, output ready);
endinterface

interface bxavg_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [bxavg_pkg::CFG_IDX_W-1:0]  index;
    logic [bxavg_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: sv/bxavg_colmem.sv
// column accumulator memory, one entry per input column, registered read
module bxavg_colmem (
    input  logic                         i_clk,
    input  bxavg_pkg::t_mem_rd           i_rd,
    input  bxavg_pkg::t_mem_wr           i_wr,
    output logic [bxavg_pkg::SUM_W-1:0]  o_rd_data
);

    logic [bxavg_pkg::SUM_W-1:0] r_mem [bxavg_pkg::MAX_WIDTH];
    logic [bxavg_pkg::SUM_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        if (i_rd.en) begin
            r_rd_data <= r_mem[i_rd.addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: sv/bxavg_geom.sv
// configuration registers, clamping and block-aligned image extent
module bxavg_geom (
    input  logic              i_clk,
    input  logic              i_rst_n,
    bxavg_cfg_if.sink         i_cfg,
    output bxavg_pkg::t_geom  o_geom,
    output logic              o_busy
);

    logic [bxavg_pkg::SIDE_W-1:0]    r_side;
    logic [bxavg_pkg::WIDTH_W-1:0]   r_width;
    logic [bxavg_pkg::HEIGHT_W-1:0]  r_height;
    logic [bxavg_pkg::SIDE_W-1:0]    side_c;
    logic [bxavg_pkg::WIDTH_W-1:0]   width_c;
    logic [bxavg_pkg::HEIGHT_W-1:0]  height_c;

    logic                            r_load;
    logic [bxavg_pkg::MOD_CNT_W-1:0] r_cnt;
    logic [bxavg_pkg::HEIGHT_W-1:0]  r_sh_w;
    logic [bxavg_pkg::HEIGHT_W-1:0]  r_sh_h;
    logic [bxavg_pkg::SIDE_W-1:0]    r_rem_w;
    logic [bxavg_pkg::SIDE_W-1:0]    r_rem_h;
    logic [bxavg_pkg::SIDE_W-1:0]    n_rem_w;
    logic [bxavg_pkg::SIDE_W-1:0]    n_rem_h;
    logic [bxavg_pkg::SIDE_W:0]      tw;
    logic [bxavg_pkg::SIDE_W:0]      th;
    logic [bxavg_pkg::COL_W:0]       r_used_cols;
    logic [bxavg_pkg::ROW_W:0]       r_used_rows;
    logic [bxavg_pkg::COL_W:0]       n_used_cols;
    logic [bxavg_pkg::ROW_W:0]       n_used_rows;
    logic                            cfg_wr;

    assign i_cfg.ready = 1'b1;
    assign cfg_wr      = i_cfg.valid;

    always_comb begin
        priority if (r_side == '0) begin
            side_c = bxavg_pkg::SIDE_W'(1);
        end else if (r_side > bxavg_pkg::SIDE_W'(bxavg_pkg::MAX_BLOCK)) begin
            side_c = bxavg_pkg::SIDE_W'(bxavg_pkg::MAX_BLOCK);
        end else begin
            side_c = r_side;
        end
        priority if (r_width == '0) begin
            width_c = bxavg_pkg::WIDTH_W'(1);
        end else if (r_width > bxavg_pkg::WIDTH_W'(bxavg_pkg::MAX_WIDTH)) begin
            width_c = bxavg_pkg::WIDTH_W'(bxavg_pkg::MAX_WIDTH);
        end else begin
            width_c = r_width;
        end
        priority if (r_height == '0) begin
            height_c = bxavg_pkg::HEIGHT_W'(1);
        end else if (r_height > bxavg_pkg::HEIGHT_W'(bxavg_pkg::MAX_HEIGHT)) begin
            height_c = bxavg_pkg::HEIGHT_W'(bxavg_pkg::MAX_HEIGHT);
        end else begin
            height_c = r_height;
        end
    end

    // one restoring remainder step per cycle for width and height in parallel
    always_comb begin
        tw = {r_rem_w, r_sh_w[bxavg_pkg::HEIGHT_W-1]};
        th = {r_rem_h, r_sh_h[bxavg_pkg::HEIGHT_W-1]};
        if (tw >= {1'b0, side_c}) begin
            n_rem_w = bxavg_pkg::SIDE_W'(tw - {1'b0, side_c});
        end else begin
            n_rem_w = bxavg_pkg::SIDE_W'(tw);
        end
        if (th >= {1'b0, side_c}) begin
            n_rem_h = bxavg_pkg::SIDE_W'(th - {1'b0, side_c});
        end else begin
            n_rem_h = bxavg_pkg::SIDE_W'(th);
        end
        n_used_cols = (bxavg_pkg::COL_W + 1)'(width_c - bxavg_pkg::WIDTH_W'(n_rem_w));
        n_used_rows = (bxavg_pkg::ROW_W + 1)'(height_c - bxavg_pkg::HEIGHT_W'(n_rem_h));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side   <= bxavg_pkg::RST_BLOCK_SIDE;
            r_width  <= bxavg_pkg::RST_IMAGE_WIDTH;
            r_height <= bxavg_pkg::RST_IMAGE_HEIGHT;
            r_load   <= 1'b1;
            r_cnt    <= '0;
        end else begin
            if (cfg_wr) begin
                unique case (bxavg_pkg::t_cfg_idx'(i_cfg.index))
                    bxavg_pkg::CFG_BLOCK_SIDE:   r_side   <= bxavg_pkg::SIDE_W'(i_cfg.data);
                    bxavg_pkg::CFG_IMAGE_WIDTH:  r_width  <= bxavg_pkg::WIDTH_W'(i_cfg.data);
                    bxavg_pkg::CFG_IMAGE_HEIGHT: r_height <= bxavg_pkg::HEIGHT_W'(i_cfg.data);
                    default: begin
                    end
                endcase
            end
            // any write restarts the extent computation
            if (cfg_wr) begin
                r_load <= 1'b1;
                r_cnt  <= '0;
            end else if (r_load) begin
                r_load <= 1'b0;
                r_cnt  <= bxavg_pkg::MOD_CNT_W'(bxavg_pkg::MOD_STEPS);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_load) begin
            r_sh_w  <= bxavg_pkg::HEIGHT_W'(width_c);
            r_sh_h  <= height_c;
            r_rem_w <= '0;
            r_rem_h <= '0;
        end else if (r_cnt != '0) begin
            r_sh_w  <= r_sh_w << 1;
            r_sh_h  <= r_sh_h << 1;
            r_rem_w <= n_rem_w;
            r_rem_h <= n_rem_h;
            if (r_cnt == bxavg_pkg::MOD_CNT_W'(1)) begin
                r_used_cols <= n_used_cols;
                r_used_rows <= n_used_rows;
            end
        end
    end

    assign o_busy = r_load || (r_cnt != '0);

    always_comb begin
        o_geom.side_m1   = bxavg_pkg::BLK_W'(side_c - 1'b1);
        o_geom.width_m1  = bxavg_pkg::COL_W'(width_c - 1'b1);
        o_geom.height_m1 = bxavg_pkg::ROW_W'(height_c - 1'b1);
        o_geom.used_cols = r_used_cols;
        o_geom.used_rows = r_used_rows;
        o_geom.recip     = bxavg_pkg::recip_of(o_geom.side_m1);
    end

endmodule

FILE: sv/bxavg_divider.sv
// block sum to mean by reciprocal multiply, one registered stage
module bxavg_divider (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  bxavg_pkg::t_div_req            i_req,
    input  logic [bxavg_pkg::RECIP_W-1:0]  i_recip,
    output logic                           o_valid,
    output bxavg_pkg::t_out_item           o_item
);

    logic [bxavg_pkg::PROD_W-1:0] prod;
    logic                         r_valid;
    bxavg_pkg::t_out_item         r_item;

    assign prod = bxavg_pkg::PROD_W'(i_req.total) * bxavg_pkg::PROD_W'(i_recip);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item.average_value <= prod[bxavg_pkg::RECIP_SHIFT +: bxavg_pkg::PIX_W];
        r_item.row_end       <= i_req.row_end;
        r_item.frame_end     <= i_req.frame_end;
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

FILE: sv/bxavg_outq.sv
// small output queue that decouples the result channel from the datapath
module bxavg_outq (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_push,
    input  bxavg_pkg::t_out_item            i_item,
    bxavg_res_if.source                     o_res,
    output logic [bxavg_pkg::OQ_CNT_W-1:0]  o_count
);

    bxavg_pkg::t_out_item            r_buf [bxavg_pkg::OQ_DEPTH];
    logic [bxavg_pkg::OQ_PTR_W-1:0]  r_wr_ptr;
    logic [bxavg_pkg::OQ_PTR_W-1:0]  r_rd_ptr;
    logic [bxavg_pkg::OQ_CNT_W-1:0]  r_count;
    logic [bxavg_pkg::OQ_CNT_W-1:0]  n_count;
    logic                            pop;
    bxavg_pkg::t_out_item            head;

    assign head                = r_buf[r_rd_ptr];
    assign o_res.valid         = (r_count != '0);
    assign o_res.average_value = head.average_value;
    assign o_res.row_end       = head.row_end;
    assign o_res.frame_end     = head.frame_end;
    assign pop                 = o_res.valid && o_res.ready;
    assign n_count             = r_count + bxavg_pkg::OQ_CNT_W'(i_push)
                                 - bxavg_pkg::OQ_CNT_W'(pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[r_wr_ptr] <= i_item;
        end
    end

    assign o_count = r_count;

endmodule

FILE: sv/box_average_downscaler.sv
// top level of the box average downscaler
//
// i_pix carries 8-bit grayscale pixels in raster order; frame_start on a pixel
// restarts the position counters at the top-left corner. o_res carries one
// item per S x S block: the truncated mean plus row_end and frame_end flags.
// Columns and rows past the last full block produce nothing. i_cfg writes
// block_side (0), image_width (1) and image_height (2); the user must write only
// while no pixel is in flight, and the block itself does not enforce this. i_cfg.ready is always high.
// Throughput: one pixel per cycle while i_pix.ready is high. A block's last pixel
// has its column accumulator read and running sum registered with it, then the
// accumulator add and the reciprocal multiply are registered in the divider, and
// the result is then written to the queue, from which it shows on o_res.
// After reset and after every configuration write, i_pix.ready stays low while
// the block-aligned width and height are computed one remainder bit per cycle.
// Reset clears positions and the running sum; the column accumulators are
// undefined until a row of blocks writes them.
// When the receiver stalls, results collect in a 4-entry queue and i_pix.ready
// drops once queued plus in-flight results would fill it.
module box_average_downscaler (
    input  logic         i_clk,
    input  logic         i_rst_n,
    bxavg_pix_if.sink    i_pix,
    bxavg_res_if.source  o_res,
    bxavg_cfg_if.sink    i_cfg
);

    bxavg_pkg::t_geom                geom;
    logic                            busy;
    logic [bxavg_pkg::OQ_CNT_W-1:0]  q_count;
    logic [bxavg_pkg::OQ_CNT_W:0]    pending;
    logic                            accept;

    logic [bxavg_pkg::COL_W-1:0]     r_col, cur_col, n_col;
    logic [bxavg_pkg::ROW_W-1:0]     r_row, cur_row, n_row;
    logic [bxavg_pkg::BLK_W-1:0]     r_rib, cur_rib, n_rib;
    logic [bxavg_pkg::BLK_W-1:0]     r_cib, cur_cib, n_cib;
    logic [bxavg_pkg::RUN_W-1:0]     r_run, cur_run, n_run;
    logic [bxavg_pkg::RUN_W-1:0]     sum_a;
    logic                            active;
    logic                            blk_end;
    logic                            rib_last;
    logic                            row_end_a;
    logic                            frame_end_a;

    logic                            r_b_valid;
    logic                            r_b_out;
    logic                            r_b_use_mem;
    logic [bxavg_pkg::COL_W-1:0]     r_b_addr;
    logic [bxavg_pkg::RUN_W-1:0]     r_b_sum;
    logic                            r_b_re;
    logic                            r_b_fe;
    logic [bxavg_pkg::SUM_W-1:0]     rd_data;
    logic [bxavg_pkg::SUM_W-1:0]     total;

    bxavg_pkg::t_mem_rd              mem_rd;
    bxavg_pkg::t_mem_wr              mem_wr;
    bxavg_pkg::t_div_req             div_req;
    logic                            div_valid;
    bxavg_pkg::t_out_item            div_item;

    bxavg_geom u_geom (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_geom  (geom),
        .o_busy  (busy)
    );

    // results that will land in the queue, counted before the next pixel goes in
    assign pending = {1'b0, q_count}
                     + (bxavg_pkg::OQ_CNT_W + 1)'(r_b_valid && r_b_out)
                     + (bxavg_pkg::OQ_CNT_W + 1)'(div_valid);
    assign i_pix.ready = !busy && (pending < (bxavg_pkg::OQ_CNT_W + 1)'(bxavg_pkg::OQ_DEPTH));
    assign accept      = i_pix.valid && i_pix.ready;

    always_comb begin
        cur_col = i_pix.frame_start ? '0 : r_col;
        cur_row = i_pix.frame_start ? '0 : r_row;
        cur_rib = i_pix.frame_start ? '0 : r_rib;
        cur_cib = i_pix.frame_start ? '0 : r_cib;
        cur_run = i_pix.frame_start ? '0 : r_run;

        active   = ({1'b0, cur_col} < geom.used_cols) && ({1'b0, cur_row} < geom.used_rows);
        blk_end  = (cur_cib >= geom.side_m1);
        rib_last = (cur_rib >= geom.side_m1);
        sum_a    = cur_run + bxavg_pkg::RUN_W'(i_pix.pixel_value);

        row_end_a   = ({1'b0, cur_col} == (geom.used_cols - 1'b1));
        frame_end_a = row_end_a && ({1'b0, cur_row} == (geom.used_rows - 1'b1));

        n_col = cur_col;
        n_row = cur_row;
        n_rib = cur_rib;
        n_cib = cur_cib;
        n_run = cur_run;
        if (active) begin
            if (blk_end) begin
                n_run = '0;
                n_cib = '0;
            end else begin
                n_run = sum_a;
                n_cib = cur_cib + 1'b1;
            end
        end
        // bounds compare with >= so a shrunk register still wraps
        if (cur_col >= geom.width_m1) begin
            n_col = '0;
            n_cib = '0;
            n_run = '0;
            if (cur_row >= geom.height_m1) begin
                n_row = '0;
                n_rib = '0;
            end else begin
                n_row = cur_row + 1'b1;
                n_rib = rib_last ? '0 : cur_rib + 1'b1;
            end
        end else begin
            n_col = cur_col + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col     <= '0;
            r_row     <= '0;
            r_rib     <= '0;
            r_cib     <= '0;
            r_run     <= '0;
            r_b_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_col <= n_col;
                r_row <= n_row;
                r_rib <= n_rib;
                r_cib <= n_cib;
                r_run <= n_run;
            end
            r_b_valid <= accept && active && blk_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_b_out     <= rib_last;
            r_b_use_mem <= (cur_rib != '0);
            r_b_addr    <= cur_col;
            r_b_sum     <= sum_a;
            r_b_re      <= row_end_a;
            r_b_fe      <= frame_end_a;
        end
    end

    // a column entry is touched once per row and rows are at least two pixels
    // wide here, so a read never meets the write of the item just before it
    always_comb begin
        mem_rd.en   = accept && active && blk_end && (cur_rib != '0);
        mem_rd.addr = cur_col;
    end

    bxavg_colmem u_colmem (
        .i_clk     (i_clk),
        .i_rd      (mem_rd),
        .i_wr      (mem_wr),
        .o_rd_data (rd_data)
    );

    assign total = bxavg_pkg::SUM_W'(r_b_sum) + (r_b_use_mem ? rd_data : '0);

    always_comb begin
        mem_wr.en         = r_b_valid && !r_b_out;
        mem_wr.addr       = r_b_addr;
        mem_wr.data       = total;
        div_req.valid     = r_b_valid && r_b_out;
        div_req.total     = total;
        div_req.row_end   = r_b_re;
        div_req.frame_end = r_b_fe;
    end

    bxavg_divider u_divider (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .i_recip (geom.recip),
        .o_valid (div_valid),
        .o_item  (div_item)
    );

    bxavg_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (div_valid),
        .i_item  (div_item),
        .o_res   (o_res),
        .o_count (q_count)
    );

endmodule

FILE: sv/bxavg_chk.sv
// port-level checks of the box average downscaler and their binding
`include "box_average_downscaler_defines.svh"

module bxavg_chk (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_ready,
    input logic                        i_out_valid,
    input logic                        i_out_ready,
    input logic [bxavg_pkg::PIX_W-1:0] i_out_average_value,
    input logic                        i_out_row_end,
    input logic                        i_out_frame_end,
    input logic                        i_cfg_valid,
    input logic                        i_cfg_ready
);

    // a stalled item stays valid and keeps its average value
    `BXAVG_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_average_value), "stalled result item changed")

    // the last block of a frame is also the last of its row
    `BXAVG_ASSERT_NOW(a_frame_row, i_clk, i_rst_n, i_out_valid && i_out_frame_end, i_out_row_end, "frame end without row end")

    // extent recompute blocks pixels right after a register write
    `BXAVG_ASSERT_NEXT(a_cfg_busy, i_clk, i_rst_n, i_cfg_valid && i_cfg_ready, !i_in_ready, "pixel taken right after a register write")

    // same after reset
    `BXAVG_ASSERT_NOW(a_rst_busy, i_clk, i_rst_n, $rose(i_rst_n), !i_in_ready, "pixel taken right after reset")

endmodule

bind box_average_downscaler bxavg_chk u_bxavg_chk (
    .i_clk               (i_clk),
    .i_rst_n             (i_rst_n),
    .i_in_ready          (i_pix.ready),
    .i_out_valid         (o_res.valid),
    .i_out_ready         (o_res.ready),
    .i_out_average_value (o_res.average_value),
    .i_out_row_end       (o_res.row_end),
    .i_out_frame_end     (o_res.frame_end),
    .i_cfg_valid         (i_cfg.valid),
    .i_cfg_ready         (i_cfg.ready)
);
